### design/pgd_pkg.sv
`timescale 1ns / 1ps
package pgd_pkg;

  // Widths fixed by the interface.
  localparam int unsigned IN_W      = 16;
  localparam int unsigned CID_W     = 10;
  localparam int unsigned STRIDE_W  = 10;
  localparam int unsigned SHIFT_W   = 3;
  localparam int unsigned PMASK_W   = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 32;

  // Soft value width and number of pass mask bits in use.
  localparam int unsigned VALUE_WIDTH = 16;
  localparam int unsigned MASK_WIDTH  = 32;
  localparam int unsigned MIDX_W      = $clog2(MASK_WIDTH);

  // Gold sequence generator.
  localparam int unsigned LFSR_W    = 31;
  localparam int unsigned GOLD_NC   = 1600;
  localparam int unsigned SKIP_W    = 14;
  localparam int unsigned STEPS     = 8;
  localparam int unsigned STEP_W    = $clog2(STEPS + 1);
  localparam int unsigned IDX_W     = 6;
  localparam logic [IDX_W-1:0] IDX_MAX = 6'h3f;

  // Queue between the front and back ends.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_ID      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_MODE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_STRIDE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PASS_MASK    = 2'd3;

  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 10'd864;

  typedef struct packed {
    logic                     first;
    logic [SHIFT_W-1:0]       seq_shift;
    logic signed [IN_W-1:0]   in_value;
    logic                     in_last;
  } pgd_in_t;

  typedef struct packed {
    logic signed [IN_W-1:0]   out_value;
    logic                     out_last;
  } pgd_out_t;

  // One queued element, already classified by the front end.
  typedef struct packed {
    logic                     first;
    logic [SKIP_W-1:0]        skip;
    logic [IN_W-1:0]          value;
    logic                     last;
  } pgd_entry_t;

  typedef struct packed {
    logic [LFSR_W-1:0] x1;
    logic [LFSR_W-1:0] x2;
  } gold_t;

  // One step of both LFSRs; bit 0 holds the oldest sequence bit.
  function automatic gold_t gold_step(input gold_t g);
    gold_t r;
    r.x1 = {g.x1[3] ^ g.x1[0], g.x1[LFSR_W-1:1]};
    r.x2 = {g.x2[3] ^ g.x2[2] ^ g.x2[1] ^ g.x2[0], g.x2[LFSR_W-1:1]};
    return r;
  endfunction

endpackage

### design/pgd_front.sv
`timescale 1ns / 1ps
module pgd_front (
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  pgd_pkg::pgd_in_t                in_data_i,
  input  logic [pgd_pkg::STRIDE_W-1:0]    shift_stride_i,
  input  logic                            q_full_i,
  output logic                            q_push_o,
  output pgd_pkg::pgd_entry_t             q_entry_o
);
  import pgd_pkg::*;

  logic [SKIP_W-1:0] prod;

  // Sequence bits to skip beyond GOLD_NC when an element starts a block.
  assign prod = SKIP_W'(in_data_i.seq_shift) * SKIP_W'(shift_stride_i);

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // Classify the element and build the queue entry.
  always_comb begin
    q_entry_o.first = in_data_i.first;
    q_entry_o.skip  = in_data_i.first ? (SKIP_W'(GOLD_NC) + prod) : '0;
    q_entry_o.value = in_data_i.in_value;
    q_entry_o.last  = in_data_i.in_last;
  end

endmodule

### design/pgd_fifo.sv
`timescale 1ns / 1ps
module pgd_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  pgd_pkg::pgd_entry_t   push_data_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  head_valid_o,
  output pgd_pkg::pgd_entry_t   head_o
);
  import pgd_pkg::*;

  pgd_entry_t          mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   count_q;

  assign full_o       = (count_q == QCNT_W'(QDEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o)
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QDEPTH))
    else $error("queue fill count out of range");
`endif

endmodule

### design/pgd_back.sv
`timescale 1ns / 1ps
module pgd_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [pgd_pkg::CID_W-1:0]      cell_id_i,
  input  logic                           bit_mode_i,
  input  logic [pgd_pkg::PMASK_W-1:0]    pass_mask_i,
  input  logic                           head_valid_i,
  input  pgd_pkg::pgd_entry_t            head_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output pgd_pkg::pgd_out_t              out_data_o
);
  import pgd_pkg::*;

  typedef enum logic {S_RUN, S_SKIP} state_e;

  state_e              state_q, state_d;
  gold_t               gold_q, gold_d;
  logic [SKIP_W-1:0]   rem_q, rem_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic                seeded_q, seeded_d;
  logic                out_valid_q, out_valid_d;
  pgd_out_t            out_q, out_d;

  gold_t                   ahead [STEPS+1];
  logic [STEP_W-1:0]       step;
  logic                    need_seed;
  logic                    fire;
  logic                    masked;
  logic                    consume;
  logic                    cbit;
  logic [VALUE_WIDTH-1:0]  v;
  logic [VALUE_WIDTH-1:0]  llr;

  // Up to STEPS generator states ahead of the current one.
  always_comb begin
    ahead[0] = gold_q;
    for (int i = 1; i <= STEPS; i++) begin
      ahead[i] = gold_step(ahead[i-1]);
    end
  end

  assign step = (rem_q >= SKIP_W'(STEPS)) ? STEP_W'(STEPS) : rem_q[STEP_W-1:0];

  // Element datapath.
  assign need_seed = head_i.first && !seeded_q;
  assign fire      = (state_q == S_RUN) && head_valid_i && !need_seed
                     && (!out_valid_q || out_ready_i);
  assign masked    = bit_mode_i && (idx_q < IDX_W'(MASK_WIDTH))
                     && pass_mask_i[idx_q[MIDX_W-1:0]];
  assign consume   = !masked;
  assign cbit      = gold_q.x1[0] ^ gold_q.x2[0];
  assign v         = head_i.value[VALUE_WIDTH-1:0];
  assign llr       = cbit ? (-v) : v;
  assign pop_o     = fire;

  // Next state of the sequencer, generator and output register.
  always_comb begin
    state_d     = state_q;
    gold_d      = gold_q;
    rem_d       = rem_q;
    idx_d       = idx_q;
    seeded_d    = seeded_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_RUN: begin
        if (head_valid_i && need_seed) begin
          gold_d.x1 = LFSR_W'(1);
          gold_d.x2 = LFSR_W'(cell_id_i);
          rem_d     = head_i.skip;
          idx_d     = '0;
          state_d   = S_SKIP;
        end else if (fire) begin
          seeded_d        = 1'b0;
          out_valid_d     = 1'b1;
          out_d.out_last  = head_i.last;
          if (bit_mode_i) begin
            out_d.out_value = IN_W'(v[0] ^ (consume & cbit));
          end else begin
            out_d.out_value = IN_W'($signed(llr));
          end
          if (consume) begin
            gold_d = ahead[1];
          end
          if (idx_q != IDX_MAX) begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      S_SKIP: begin
        gold_d = ahead[step];
        rem_d  = rem_q - SKIP_W'(step);
        if (rem_d == '0) begin
          seeded_d = 1'b1;
          state_d  = S_RUN;
        end
      end
      default: state_d = S_RUN;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RUN;
      gold_q.x1   <= LFSR_W'(1);
      gold_q.x2   <= '0;
      rem_q       <= '0;
      idx_q       <= '0;
      seeded_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      gold_q      <= gold_d;
      rem_q       <= rem_d;
      idx_q       <= idx_d;
      seeded_q    <= seeded_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_skip_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SKIP) |-> (rem_q != '0))
    else $error("fast-forward running with nothing left to skip");
  a_no_pop_in_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SKIP) |-> !pop_o)
    else $error("element taken during fast-forward");
  a_seed_enters_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_RUN) && head_valid_i && need_seed) |=> (state_q == S_SKIP))
    else $error("block start did not start the fast-forward");
`endif

endmodule

### design/pbch_gold_descrambler.sv
`timescale 1ns / 1ps
// PBCH Gold sequence descrambler.
// Input transactions (in_valid_i/in_ready_o, in_data_i) carry one element of a
// PBCH block; output transactions (out_valid_o/out_ready_i, out_data_o) carry
// one descrambled element per input element, in order.
// The cfg_we_i/cfg_idx_i/cfg_data_i port writes one of cell id, bit mode,
// shift stride and pass mask per write; write it only while the block is idle.
// A front end computes the skip count and places elements in a two-entry
// queue; a back end runs the Gold generator and holds the output register.
// An element inside a block passes through the queue and the output register
// before it is offered on the output. An element marked first reseeds the
// generator and then fast-forwards it by 1600 plus seq_shift*shift_stride
// bits, eight bits a cycle, before that element is taken. After that one
// element is taken per cycle while one waits and the receiver is ready.
// Reset clears the queue, the generator (x1 = 1, x2 = 0) and the element
// index, and loads the register reset values. When the receiver stalls, the
// output register holds its transaction, the queue fills, and in_ready_o
// drops once two elements wait.
module pbch_gold_descrambler (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  pgd_pkg::pgd_in_t                  in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output pgd_pkg::pgd_out_t                 out_data_o,
  input  logic                              cfg_we_i,
  input  logic [pgd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [pgd_pkg::CFG_W-1:0]         cfg_data_i
);
  import pgd_pkg::*;

  logic [CID_W-1:0]    cell_id_q;
  logic                bit_mode_q;
  logic [STRIDE_W-1:0] shift_stride_q;
  logic [PMASK_W-1:0]  pass_mask_q;

  logic        q_full, q_push, q_pop, q_head_valid;
  pgd_entry_t  q_entry, q_head;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_id_q      <= '0;
      bit_mode_q     <= 1'b0;
      shift_stride_q <= STRIDE_RESET;
      pass_mask_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CELL_ID:      cell_id_q      <= cfg_data_i[CID_W-1:0];
        CFG_BIT_MODE:     bit_mode_q     <= cfg_data_i[0];
        CFG_SHIFT_STRIDE: shift_stride_q <= cfg_data_i[STRIDE_W-1:0];
        CFG_PASS_MASK:    pass_mask_q    <= cfg_data_i[PMASK_W-1:0];
        default:          cell_id_q      <= cell_id_q;
      endcase
    end
  end

  pgd_front u_front (
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_data_i      (in_data_i),
    .shift_stride_i (shift_stride_q),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_entry_o      (q_entry)
  );

  pgd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_data_i  (q_entry),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .head_valid_o (q_head_valid),
    .head_o       (q_head)
  );

  pgd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cell_id_i    (cell_id_q),
    .bit_mode_i   (bit_mode_q),
    .pass_mask_i  (pass_mask_q),
    .head_valid_i (q_head_valid),
    .head_i       (q_head),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule
